### hw/rtl/gnos_pkg.sv
// Shared constants, codes and types for the gradient noise octave sum block.
package gnos_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int TABLE_AW        = $clog2(TABLE_SIZE);
    localparam int VAL_W           = 8;
    localparam int MAX_OCTAVES_DEF = 8;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int NOISE_W   = 19;
    localparam int FREQ_W    = 24;
    localparam int AMP_W     = 32;
    localparam int OUT_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREE_D   = 3'd0,
        CFG_OCTAVES   = 3'd1,
        CFG_PERSIST   = 3'd2,
        CFG_LACUN     = 3'd3,
        CFG_BASE_FREQ = 3'd4
    } cfg_index_t;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic        RST_THREE_D   = 1'b1;
    localparam logic [3:0]  RST_OCTAVES   = 4'd4;
    localparam logic [15:0] RST_PERSIST   = 16'd8192;
    localparam logic [15:0] RST_LACUN     = 16'd8192;
    localparam logic [23:0] RST_BASE_FREQ = 24'd65536;
    localparam logic [31:0] AMP_ONE       = 32'd65536;

    typedef struct packed {
        logic                 start;
        logic                 three_d;
        logic signed [31:0]   coord_x;
        logic signed [31:0]   coord_y;
        logic signed [31:0]   coord_z;
        logic [FREQ_W-1:0]    freq;
    } noise_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [NOISE_W-1:0] value;
    } noise_rsp_t;

endpackage

### hw/rtl/gnos_if.sv
// Valid/ready channel interfaces for sample items and result items.
interface gnos_sample_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [7:0]         table_index;
    logic [7:0]         table_value;

    modport source (output valid, action, coord_x, coord_y, coord_z, table_index,
                    table_value, input ready);
    modport sink (input valid, action, coord_x, coord_y, coord_z, table_index,
                  table_value, output ready);
endinterface

interface gnos_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink (input valid, noise_value, output ready);
endinterface

### hw/rtl/gnos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gnos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/gnos_noise.sv
// One-octave gradient noise unit: split, fade, table hashing, gradients and lerps.
module gnos_noise (
    input  logic                clk,
    input  logic                rst_n,
    input  gnos_pkg::noise_req_t req,
    output gnos_pkg::noise_rsp_t rsp,
    output logic [7:0]          ram_addr,
    input  logic [7:0]          ram_rdata
);

    typedef enum logic [8:0] {
        N_IDLE  = 9'b000000001,
        N_SPLIT = 9'b000000010,
        N_F1    = 9'b000000100,
        N_F2    = 9'b000001000,
        N_F3    = 9'b000010000,
        N_HASH  = 9'b000100000,
        N_WAIT  = 9'b001000000,
        N_GRAD  = 9'b010000000,
        N_LERP  = 9'b100000000
    } noise_state_t;

    noise_state_t state_reg, state_next;
    logic [1:0]   ax_reg, ax_next;
    logic [3:0]   step_reg, step_next;
    logic [2:0]   lj_reg, lj_next;
    logic         rd_pend_reg;
    logic [3:0]   rd_idx_reg;
    logic         done_reg, done_next;

    logic [7:0]  cell_reg [3];
    logic [15:0] frac_reg [3];
    logic [16:0] fade_reg [3];
    logic [15:0] t2_reg;
    logic [15:0] t3_reg;
    logic [20:0] inner_reg;
    logic [7:0]  hv_reg [14];
    logic signed [18:0] gv_reg [8];
    logic signed [18:0] lv_reg [7];
    logic signed [18:0] value_reg;

    logic [15:0]        t_cur;
    logic signed [31:0] coord_sel;
    logic signed [56:0] split_prod;
    logic [31:0]        sq;
    logic [31:0]        cube;
    logic [20:0]        inner_c;
    logic [36:0]        fprod;
    logic [20:0]        fsh;
    logic [16:0]        fade_c;
    logic [1:0]         ax_last;
    logic [3:0]         step_last;
    logic [2:0]         lerp_last;
    logic signed [18:0] xf, yf, zf, xg, yg, zg;
    logic signed [18:0] g_c [8];
    logic signed [18:0] la, lb;
    logic [16:0]        lw;
    logic signed [19:0] ldiff;
    logic signed [37:0] lprod;
    logic signed [18:0] lres;

    function automatic logic signed [18:0] grad2(input logic [7:0] h,
                                                 input logic signed [18:0] x,
                                                 input logic signed [18:0] y);
        logic signed [18:0] r;
        begin
            case (h[1:0])
                2'd0:    r = x + y;
                2'd1:    r = -x + y;
                2'd2:    r = x - y;
                default: r = -x - y;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [18:0] grad3(input logic [7:0] h,
                                                 input logic signed [18:0] x,
                                                 input logic signed [18:0] y,
                                                 input logic signed [18:0] z);
        logic [3:0]         hl;
        logic signed [18:0] u;
        logic signed [18:0] v;
        logic signed [18:0] su;
        logic signed [18:0] sv;
        begin
            hl = h[3:0];
            u  = (hl < 4'd8) ? x : y;
            v  = (hl < 4'd4) ? y : (((hl == 4'd12) || (hl == 4'd14)) ? x : z);
            su = hl[0] ? -u : u;
            sv = hl[1] ? -v : v;
            return su + sv;
        end
    endfunction

    assign ax_last   = req.three_d ? 2'd2 : 2'd1;
    assign step_last = req.three_d ? 4'd13 : 4'd5;
    assign lerp_last = req.three_d ? 3'd6 : 3'd2;

    always_comb
    begin
        t_cur = frac_reg[ax_reg];
        case (ax_reg)
            2'd0:    coord_sel = req.coord_x;
            2'd1:    coord_sel = req.coord_y;
            default: coord_sel = req.coord_z;
        endcase
        split_prod = 57'(coord_sel) * $signed({33'd0, req.freq});
        sq         = 32'(t_cur) * 32'(t_cur);
        cube       = 32'(t2_reg) * 32'(t_cur);
        inner_c    = 21'(t2_reg) * 21'd6 + 21'd655360 - 21'(t_cur) * 21'd15;
        fprod      = 37'(t3_reg) * 37'(inner_reg);
        fsh        = fprod[36:16];
        fade_c     = (fsh > 21'd65536) ? 17'd65536 : fsh[16:0];
    end

    always_comb
    begin
        case (step_reg)
            4'd0:    ram_addr = cell_reg[0];
            4'd1:    ram_addr = cell_reg[0] + 8'd1;
            4'd2:    ram_addr = hv_reg[0] + cell_reg[1];
            4'd3:    ram_addr = hv_reg[0] + cell_reg[1] + 8'd1;
            4'd4:    ram_addr = hv_reg[1] + cell_reg[1];
            4'd5:    ram_addr = hv_reg[1] + cell_reg[1] + 8'd1;
            4'd6:    ram_addr = hv_reg[2] + cell_reg[2];
            4'd7:    ram_addr = hv_reg[4] + cell_reg[2];
            4'd8:    ram_addr = hv_reg[3] + cell_reg[2];
            4'd9:    ram_addr = hv_reg[5] + cell_reg[2];
            4'd10:   ram_addr = hv_reg[2] + cell_reg[2] + 8'd1;
            4'd11:   ram_addr = hv_reg[4] + cell_reg[2] + 8'd1;
            4'd12:   ram_addr = hv_reg[3] + cell_reg[2] + 8'd1;
            4'd13:   ram_addr = hv_reg[5] + cell_reg[2] + 8'd1;
            default: ram_addr = cell_reg[0];
        endcase
    end

    always_comb
    begin
        xf = $signed({3'd0, frac_reg[0]});
        yf = $signed({3'd0, frac_reg[1]});
        zf = $signed({3'd0, frac_reg[2]});
        xg = xf - 19'sd65536;
        yg = yf - 19'sd65536;
        zg = zf - 19'sd65536;
        if (req.three_d)
        begin
            g_c[0] = grad3(hv_reg[6],  xf, yf, zf);
            g_c[1] = grad3(hv_reg[7],  xg, yf, zf);
            g_c[2] = grad3(hv_reg[8],  xf, yg, zf);
            g_c[3] = grad3(hv_reg[9],  xg, yg, zf);
            g_c[4] = grad3(hv_reg[10], xf, yf, zg);
            g_c[5] = grad3(hv_reg[11], xg, yf, zg);
            g_c[6] = grad3(hv_reg[12], xf, yg, zg);
            g_c[7] = grad3(hv_reg[13], xg, yg, zg);
        end
        else
        begin
            g_c[0] = grad2(hv_reg[2], xf, yf);
            g_c[1] = grad2(hv_reg[4], xg, yf);
            g_c[2] = grad2(hv_reg[3], xf, yg);
            g_c[3] = grad2(hv_reg[5], xg, yg);
            g_c[4] = '0;
            g_c[5] = '0;
            g_c[6] = '0;
            g_c[7] = '0;
        end
    end

    always_comb
    begin
        if (!req.three_d && (lj_reg == 3'd2))
        begin
            la = lv_reg[0];
            lb = lv_reg[1];
            lw = fade_reg[1];
        end
        else
        begin
            case (lj_reg)
                3'd0:    begin la = gv_reg[0]; lb = gv_reg[1]; lw = fade_reg[0]; end
                3'd1:    begin la = gv_reg[2]; lb = gv_reg[3]; lw = fade_reg[0]; end
                3'd2:    begin la = gv_reg[4]; lb = gv_reg[5]; lw = fade_reg[0]; end
                3'd3:    begin la = gv_reg[6]; lb = gv_reg[7]; lw = fade_reg[0]; end
                3'd4:    begin la = lv_reg[0]; lb = lv_reg[1]; lw = fade_reg[1]; end
                3'd5:    begin la = lv_reg[2]; lb = lv_reg[3]; lw = fade_reg[1]; end
                default: begin la = lv_reg[4]; lb = lv_reg[5]; lw = fade_reg[2]; end
            endcase
        end
        ldiff = 20'(lb) - 20'(la);
        lprod = $signed({1'b0, lw}) * ldiff;
        lres  = la + 19'(lprod >>> 16);
    end

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        step_next  = step_reg;
        lj_next    = lj_reg;
        done_next  = 1'b0;
        case (state_reg)
            N_IDLE:
            begin
                if (req.start)
                begin
                    ax_next    = 2'd0;
                    state_next = N_SPLIT;
                end
            end
            N_SPLIT: state_next = N_F1;
            N_F1:    state_next = N_F2;
            N_F2:    state_next = N_F3;
            N_F3:
            begin
                if (ax_reg == ax_last)
                begin
                    step_next  = 4'd0;
                    state_next = N_HASH;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = N_SPLIT;
                end
            end
            N_HASH:
            begin
                if (step_reg == step_last)
                begin
                    state_next = N_WAIT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            N_WAIT: state_next = N_GRAD;
            N_GRAD:
            begin
                lj_next    = 3'd0;
                state_next = N_LERP;
            end
            N_LERP:
            begin
                if (lj_reg == lerp_last)
                begin
                    done_next  = 1'b1;
                    state_next = N_IDLE;
                end
                else
                begin
                    lj_next = lj_reg + 3'd1;
                end
            end
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= N_IDLE;
            ax_reg      <= 2'd0;
            step_reg    <= 4'd0;
            lj_reg      <= 3'd0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ax_reg      <= ax_next;
            step_reg    <= step_next;
            lj_reg      <= lj_next;
            rd_pend_reg <= (state_reg == N_HASH);
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= step_reg;
        if (rd_pend_reg)
        begin
            hv_reg[rd_idx_reg] <= ram_rdata;
        end
        case (state_reg)
            N_SPLIT:
            begin
                cell_reg[ax_reg] <= split_prod[39:32];
                frac_reg[ax_reg] <= split_prod[31:16];
            end
            N_F1: t2_reg <= sq[31:16];
            N_F2:
            begin
                t3_reg    <= cube[31:16];
                inner_reg <= inner_c;
            end
            N_F3: fade_reg[ax_reg] <= fade_c;
            N_GRAD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    gv_reg[i] <= g_c[i];
                end
            end
            N_LERP:
            begin
                lv_reg[lj_reg] <= lres;
                value_reg      <= lres;
            end
            default: ;
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

### hw/rtl/gnos_div.sv
// Restoring divider with truncation toward zero and Q1.15 saturation.
module gnos_div #(
    parameter int NUM_W = 55,
    parameter int DEN_W = 36
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [15:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               neg_reg;
    logic [NUM_W-1:0]   q_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;

    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_sub;
    logic               fits;
    logic [NUM_W-1:0]   mag;

    assign mag     = dividend[NUM_W-1] ? (-dividend) : dividend;
    assign rem_sh  = {rem_reg, q_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[NUM_W-1];
            q_reg   <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quot = (q_reg >= NUM_W'(32768)) ? -16'sd32768 : -$signed(q_reg[15:0]);
        end
        else
        begin
            quot = (q_reg > NUM_W'(32767)) ? 16'sd32767 : $signed(q_reg[15:0]);
        end
    end

    assign done = done_reg;

endmodule

### hw/rtl/gradient_noise_octave_sum_top.sv
// Top level of the gradient noise octave sum block.
// Usage:
//   sample channel: action ACT_LOAD writes table_value at table_index of the
//   256-entry permutation table and returns nothing; ACT_EVAL samples fractal
//   noise at (coord_x, coord_y, coord_z) and returns one noise_value on the
//   result channel. Evaluate only after every table entry it may touch is loaded.
//   Configuration: cfg_write with cfg_index and cfg_data sets a register; the user
//   must write it only while the block is idle, which the block does not enforce;
//   index 0 three_dimensional, 1 octave_count, 2 persistence, 3 lacunarity, 4 base_frequency.
//   Evaluation length is set by the one-read-port table walk and the shared
//   lerp multiplier for each octave, plus the bit-serial normalizing divide.
//   One item is in work at a time; the sample channel is ready only when idle.
//   The result waits in an output register; a new sample is taken while it
//   waits, and the next result holds until the receiver takes the previous one.
//   Reset: configuration registers return to their defaults, the table content is undefined.
module gradient_noise_octave_sum_top #(
    parameter int MAX_OCTAVES = gnos_pkg::MAX_OCTAVES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gnos_sample_if.sink                     sample,
    gnos_result_if.source                   result,
    input  logic                            cfg_write,
    input  logic [gnos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gnos_pkg::CFG_W-1:0]      cfg_data
);

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int CMP_W = (OCT_W > 4) ? OCT_W : 4;
    localparam int SUM_W = gnos_pkg::AMP_W + OCT_W;
    localparam int DEN_W = SUM_W + 1;
    localparam int PRD_W = gnos_pkg::AMP_W + 1 + gnos_pkg::NOISE_W;
    localparam int TOT_W = PRD_W + OCT_W;

    typedef enum logic [6:0] {
        T_IDLE  = 7'b0000001,
        T_START = 7'b0000010,
        T_WAIT  = 7'b0000100,
        T_ACC   = 7'b0001000,
        T_DIV   = 7'b0010000,
        T_DWAIT = 7'b0100000,
        T_OUT   = 7'b1000000
    } top_state_t;

    top_state_t state_reg, state_next;

    logic        three_d_reg;
    logic [3:0]  octaves_reg;
    logic [15:0] persist_reg;
    logic [15:0] lacun_reg;
    logic [23:0] base_freq_reg;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [gnos_pkg::FREQ_W-1:0] freq_reg;
    logic [gnos_pkg::AMP_W-1:0]  amp_reg;
    logic signed [TOT_W-1:0]     total_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [OCT_W-1:0]            cnt_reg;
    logic [OCT_W-1:0]            n_oct_reg;
    logic signed [gnos_pkg::NOISE_W-1:0] nv_reg;
    logic                        out_valid_reg;
    logic signed [15:0]          out_data_reg;

    logic                 accept;
    logic                 ram_we;
    logic [7:0]           ram_raddr;
    logic [7:0]           ram_rdata;
    gnos_pkg::noise_req_t nreq;
    gnos_pkg::noise_rsp_t nrsp;
    logic                 div_done;
    logic signed [15:0]   div_quot;
    logic                 out_load;

    logic [CMP_W-1:0]          oc_ext;
    logic [CMP_W-1:0]          max_ext;
    logic [CMP_W-1:0]          n_sel;
    logic signed [PRD_W-1:0]   acc_prod;
    logic [47:0]               amp_prod;
    logic [39:0]               freq_prod;
    logic [gnos_pkg::AMP_W-1:0]  amp_upd;
    logic [gnos_pkg::FREQ_W-1:0] freq_upd;

    assign sample.ready = (state_reg == T_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign ram_we       = accept && (sample.action == gnos_pkg::ACT_LOAD);
    assign out_load     = (state_reg == T_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        oc_ext   = CMP_W'(octaves_reg);
        max_ext  = CMP_W'(MAX_OCTAVES);
        if (oc_ext == '0)
        begin
            n_sel = CMP_W'(1);
        end
        else
        begin
            n_sel = (oc_ext > max_ext) ? max_ext : oc_ext;
        end
        acc_prod  = $signed({1'b0, amp_reg}) * nv_reg;
        amp_prod  = 48'(amp_reg) * 48'(persist_reg);
        freq_prod = 40'(freq_reg) * 40'(lacun_reg);
        amp_upd   = (amp_prod[47:46] != 2'd0) ? '1 : amp_prod[45:14];
        freq_upd  = (freq_prod[39:36] != 4'd0) ? '1 : freq_prod[35:12];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept && (sample.action == gnos_pkg::ACT_EVAL))
                begin
                    state_next = T_START;
                end
            end
            T_START: state_next = T_WAIT;
            T_WAIT:
            begin
                if (nrsp.done)
                begin
                    state_next = T_ACC;
                end
            end
            T_ACC:
            begin
                state_next = ((cnt_reg + 1'b1) == n_oct_reg) ? T_DIV : T_START;
            end
            T_DIV: state_next = T_DWAIT;
            T_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_load)
                begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            three_d_reg   <= gnos_pkg::RST_THREE_D;
            octaves_reg   <= gnos_pkg::RST_OCTAVES;
            persist_reg   <= gnos_pkg::RST_PERSIST;
            lacun_reg     <= gnos_pkg::RST_LACUN;
            base_freq_reg <= gnos_pkg::RST_BASE_FREQ;
            cnt_reg       <= '0;
            n_oct_reg     <= OCT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    gnos_pkg::CFG_THREE_D:   three_d_reg   <= cfg_data[0];
                    gnos_pkg::CFG_OCTAVES:   octaves_reg   <= cfg_data[3:0];
                    gnos_pkg::CFG_PERSIST:   persist_reg   <= cfg_data[15:0];
                    gnos_pkg::CFG_LACUN:     lacun_reg     <= cfg_data[15:0];
                    gnos_pkg::CFG_BASE_FREQ: base_freq_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                cnt_reg   <= '0;
                n_oct_reg <= OCT_W'(n_sel);
            end
            else if (state_reg == T_ACC)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg    <= sample.coord_x;
            cy_reg    <= sample.coord_y;
            cz_reg    <= sample.coord_z;
            freq_reg  <= base_freq_reg;
            amp_reg   <= gnos_pkg::AMP_ONE;
            total_reg <= '0;
            sum_reg   <= '0;
        end
        if ((state_reg == T_WAIT) && nrsp.done)
        begin
            nv_reg <= nrsp.value;
        end
        if (state_reg == T_ACC)
        begin
            total_reg <= total_reg + TOT_W'(acc_prod);
            sum_reg   <= sum_reg + SUM_W'(amp_reg);
            amp_reg   <= amp_upd;
            freq_reg  <= freq_upd;
        end
        if (out_load)
        begin
            out_data_reg <= div_quot;
        end
    end

    always_comb
    begin
        nreq.start   = (state_reg == T_START);
        nreq.three_d = three_d_reg;
        nreq.coord_x = cx_reg;
        nreq.coord_y = cy_reg;
        nreq.coord_z = cz_reg;
        nreq.freq    = freq_reg;
    end

    gnos_ram #(
        .WIDTH (gnos_pkg::VAL_W),
        .DEPTH (gnos_pkg::TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sample.table_index),
        .wdata (sample.table_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gnos_noise u_noise (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (nreq),
        .rsp       (nrsp),
        .ram_addr  (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    gnos_div #(
        .NUM_W (TOT_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == T_DIV),
        .dividend (total_reg),
        .divisor  ({sum_reg, 1'b0}),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign result.valid       = out_valid_reg;
    assign result.noise_value = out_data_reg;

    a_table_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == T_IDLE))
        else $error("table write while an evaluation is in progress");

    a_octave_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_START) |-> (cnt_reg < n_oct_reg))
        else $error("octave started beyond the octave count");

    a_noise_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        nrsp.done |-> (state_reg == T_WAIT))
        else $error("noise unit finished while not awaited");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_OUT))
        else $error("result presented without a finished evaluation");

endmodule
